### hdl/fwcei_pkg.sv
package fwcei_pkg;

	localparam int unsigned OUT_DEPTH = 8;
	localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [8:0]  PN9_MASK     = 9'h1E0;
	localparam logic [8:0]  PN9_RESET    = 9'h1FF;
	localparam logic [10:0] TRELLIS_RESET = 11'h000;
	localparam logic [7:0]  LENGTH_RESET = 8'hFF;
	localparam logic [7:0]  TERM_RESET   = 8'h0B;

	// Output symbol pair for each 4-bit window of the trellis register
	localparam logic [1:0] SYM_TABLE [16] = '{
		2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
		2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
	};

	typedef enum logic [1:0] {
		CFG_PACKET_LENGTH   = 2'd0,
		CFG_WHITENING_SEED  = 2'd1,
		CFG_TRELLIS_SEED    = 2'd2,
		CFG_TERMINATOR_BYTE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic            final_group;
		logic [3:0][7:0] coded;
	} out_item_t;

	function automatic logic [8:0] pn9_advance4(input logic [8:0] p);
		logic [8:0] t;
		t = ((p << 5) ^ p) & PN9_MASK;
		return t | (p >> 4);
	endfunction

	function automatic logic [8:0] pn9_advance8(input logic [8:0] p);
		return pn9_advance4(pn9_advance4(p));
	endfunction

	// Eight symbols from sliding 4-bit windows of the 11-bit register, first at the top
	function automatic logic [15:0] conv_codeword(input logic [10:0] v);
		logic [15:0] cw;
		cw = '0;
		for (int k = 0; k < 8; k++) begin
			cw[15 - 2*k -: 2] = SYM_TABLE[v[10 - k -: 4]];
		end
		return cw;
	endfunction

	function automatic out_item_t interleave_group(input logic [15:0] c0, input logic [15:0] c1,
		input logic fin);
		out_item_t it;
		it.final_group = fin;
		for (int k = 0; k < 4; k++) begin
			it.coded[k] = {c1[2*k +: 2], c1[8 + 2*k +: 2], c0[2*k +: 2], c0[8 + 2*k +: 2]};
		end
		return it;
	endfunction

endpackage

### hdl/fwcei_in_if.sv
interface fwcei_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

### hdl/fwcei_out_if.sv
interface fwcei_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] coded_byte0;
	logic [7:0] coded_byte1;
	logic [7:0] coded_byte2;
	logic [7:0] coded_byte3;
	logic       final_group;

	modport source (output valid, output coded_byte0, output coded_byte1, output coded_byte2,
		output coded_byte3, output final_group, input ready);
	modport sink (input valid, input coded_byte0, input coded_byte1, input coded_byte2,
		input coded_byte3, input final_group, output ready);
endinterface

### hdl/fwcei_out_fifo.sv
// Result queue: up to two writes per cycle (wr0 first), one read
module fwcei_out_fifo
	import fwcei_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr0_en,
	input  out_item_t            wr0_item,
	input  logic                 wr1_en,
	input  out_item_t            wr1_item,
	input  logic                 rd_en,
	output out_item_t            rd_item,
	output logic [OUT_CNT_W-1:0] count
);

	out_item_t             mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wr_ptr_q;
	logic [OUT_PTR_W-1:0]  rd_ptr_q;
	logic [OUT_CNT_W-1:0]  cnt_q;
	logic [OUT_PTR_W-1:0]  wr1_addr;

	assign wr1_addr = wr_ptr_q + {{(OUT_PTR_W-1){1'b0}}, wr0_en};

	always_ff @(posedge clk) begin
		if (wr0_en) begin
			mem_q[wr_ptr_q] <= wr0_item;
		end
		if (wr1_en) begin
			mem_q[wr1_addr] <= wr1_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(wr0_en) + OUT_PTR_W'(wr1_en);
			rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(rd_en);
			cnt_q    <= cnt_q + OUT_CNT_W'(wr0_en) + OUT_CNT_W'(wr1_en) - OUT_CNT_W'(rd_en);
		end
	end

	assign rd_item = mem_q[rd_ptr_q];
	assign count   = cnt_q;

endmodule

### hdl/fec_whiten_conv_encode_interleave_top.sv
// PN9 whitening + rate-1/2 K=4 convolutional encoder + pairwise interleaver, byte-serial.
// One data byte is accepted per cycle. At accept the byte is XORed with the low eight bits
// of the PN9 register (which steps eight bits), OR-ed into the 11-bit trellis register, and
// the trellis/whitening/count state is updated at once, so the next byte can follow in the
// next cycle. The combined 11-bit value is registered (stage 1); in the following cycle the
// 16-bit codeword and any terminator codewords are formed and written as four-byte groups
// into an eight-entry output queue, so a group reaches the output channel only after its
// completing byte has passed stage 1 and been written into the queue. A group is produced
// for every second byte;
// the last byte of a packet produces one group (odd packet length, padded with one coded
// terminator) or two groups (even length, padded with two), the last flagged final_group.
// Sustained rate is one byte per cycle; input ready drops only when the queue plus the
// byte in stage 1 could overflow it, i.e. when the output side has stalled. Configuration
// is a write-only register port; seed writes also load the live state when no packet is
// in progress, and a length of 0 means 256 bytes.
module fec_whiten_conv_encode_interleave_top
	import fwcei_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [10:0]  cfg_data,
	fwcei_in_if.sink     in_ch,
	fwcei_out_if.source  out_ch
);

	// configuration
	logic [7:0]  pkt_len_q;
	logic [8:0]  white_seed_q;
	logic [10:0] trel_seed_q;
	logic [7:0]  term_q;

	// running packet state
	logic [8:0]  lfsr_q;
	logic [10:0] trellis_q;
	logic [7:0]  bytes_q;
	logic        odd_q;

	// stage 1
	logic        valid_s1;
	logic [10:0] tval_s1;
	logic        odd_s1;
	logic        last_s1;
	logic [7:0]  term_s1;

	logic [15:0] held_q;

	logic        accept;
	logic        idle;
	logic [8:0]  len_ext;
	logic [8:0]  count_ext;
	logic        last;
	logic [7:0]  whitened;
	logic [10:0] tval;

	logic [15:0] cw_data;
	logic [15:0] cw_term0;
	logic [15:0] cw_term1;

	logic                 wr0_en;
	logic                 wr1_en;
	out_item_t            wr0_item;
	out_item_t            wr1_item;
	out_item_t            rd_item;
	logic [OUT_CNT_W-1:0] q_count;
	logic [OUT_CNT_W:0]   q_need;

	// Room for the byte in stage 1 and a new one, two groups each at worst
	assign q_need      = {1'b0, q_count} + (valid_s1 ? (OUT_CNT_W+1)'(2) : '0);
	assign in_ch.ready = q_need <= (OUT_CNT_W+1)'(OUT_DEPTH - 2);
	assign accept      = in_ch.valid & in_ch.ready;

	assign idle      = (bytes_q == '0) && !odd_q;
	assign len_ext   = (pkt_len_q == '0) ? 9'd256 : {1'b0, pkt_len_q};
	assign count_ext = {1'b0, bytes_q} + 9'd1;
	assign last      = count_ext >= len_ext;
	assign whitened  = in_ch.data_byte ^ lfsr_q[7:0];
	assign tval      = trellis_q | {3'b000, whitened};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_len_q    <= LENGTH_RESET;
			white_seed_q <= PN9_RESET;
			trel_seed_q  <= TRELLIS_RESET;
			term_q       <= TERM_RESET;
			lfsr_q       <= PN9_RESET;
			trellis_q    <= TRELLIS_RESET;
			bytes_q      <= '0;
			odd_q        <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last) begin
					// packet closes: back to the seeds
					lfsr_q    <= white_seed_q;
					trellis_q <= trel_seed_q;
					bytes_q   <= '0;
					odd_q     <= 1'b0;
				end else begin
					// eight shifts leave the low three bits at the top
					lfsr_q    <= pn9_advance8(lfsr_q);
					trellis_q <= {tval[2:0], 8'h00};
					bytes_q   <= count_ext[7:0];
					odd_q     <= ~odd_q;
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PACKET_LENGTH: begin
						pkt_len_q <= cfg_data[7:0];
					end
					CFG_WHITENING_SEED: begin
						white_seed_q <= cfg_data[8:0];
						if (idle) begin
							lfsr_q <= cfg_data[8:0];
						end
					end
					CFG_TRELLIS_SEED: begin
						trel_seed_q <= cfg_data;
						if (idle) begin
							trellis_q <= cfg_data;
						end
					end
					CFG_TERMINATOR_BYTE: begin
						term_q <= cfg_data[7:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tval_s1 <= tval;
			odd_s1  <= odd_q;
			last_s1 <= last;
			term_s1 <= term_q;
		end
	end

	// Stage 2: codewords. Terminators enter after the data byte's eight shifts.
	assign cw_data  = conv_codeword(tval_s1);
	assign cw_term0 = conv_codeword({tval_s1[2:0], term_s1});
	assign cw_term1 = conv_codeword({term_s1[2:0], term_s1});

	always_ff @(posedge clk) begin
		if (valid_s1 && !odd_s1 && !last_s1) begin
			held_q <= cw_data;
		end
	end

	assign wr0_en   = valid_s1 && (odd_s1 || last_s1);
	assign wr1_en   = valid_s1 && odd_s1 && last_s1;
	assign wr0_item = odd_s1 ? interleave_group(held_q, cw_data, 1'b0)
	                         : interleave_group(cw_data, cw_term0, 1'b1);
	assign wr1_item = interleave_group(cw_term0, cw_term1, 1'b1);

	fwcei_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr0_en   (wr0_en),
		.wr0_item (wr0_item),
		.wr1_en   (wr1_en),
		.wr1_item (wr1_item),
		.rd_en    (out_ch.valid & out_ch.ready),
		.rd_item  (rd_item),
		.count    (q_count)
	);

	assign out_ch.valid       = q_count != '0;
	assign out_ch.coded_byte0 = rd_item.coded[0];
	assign out_ch.coded_byte1 = rd_item.coded[1];
	assign out_ch.coded_byte2 = rd_item.coded[2];
	assign out_ch.coded_byte3 = rd_item.coded[3];
	assign out_ch.final_group = rd_item.final_group;

endmodule

### hdl/fwcei_checker.sv
module fwcei_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] coded_byte0,
	input logic       final_group
);

	// output item holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(coded_byte0) && $stable(final_group))
		else $error("stalled output item changed");

	// output valid rises only for an accepted byte that has passed stage 1 and the queue write
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output item without an accepted byte");

	// queue is empty once reset has been seen at an edge
	a_reset_empty: assert property (@(posedge clk)
		!arst_n && $past(!arst_n) |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind fec_whiten_conv_encode_interleave_top fwcei_checker u_fwcei_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.coded_byte0 (out_ch.coded_byte0),
	.final_group (out_ch.final_group)
);
